[hdl/b64dec_pkg.sv]
// Shared types, status codes and character lookup for the Base64 text decoder.
`default_nettype none

package b64dec_pkg;

  // end-of-message status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
  localparam logic [2:0] ST_BAD_PAD   = 3'd3;
  localparam logic [2:0] ST_HIGH_BYTE = 3'd4;

  localparam logic [7:0] PAD_CHAR  = 8'h3d;
  localparam logic [7:0] BYTE_MAX  = 8'h7f;

  // one result transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [2:0] status;
  } result_t;

  // sextet lookup: bit 6 set means not a Base64 character
  typedef logic [6:0] sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    logic [7:0] diff;
    sextet_t    res;
    diff = 8'd0;
    res  = 7'h40;
    case (ch) inside
      [8'h41:8'h5a]: begin
        diff = ch - 8'h41;
        res  = {1'b0, diff[5:0]};
      end
      [8'h61:8'h7a]: begin
        diff = ch - 8'h61 + 8'd26;
        res  = {1'b0, diff[5:0]};
      end
      [8'h30:8'h39]: begin
        diff = ch - 8'h30 + 8'd52;
        res  = {1'b0, diff[5:0]};
      end
      8'h2b: res = {1'b0, 6'd62};
      8'h2f: res = {1'b0, 6'd63};
      default: res = 7'h40;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/base64_text_decoder.sv]
// Base64 text decoder top level: input register, decode step, result queue.
`default_nettype none

// Decodes a Base64 message one character per transfer; last_char flags the
// final character. Decoded bytes come out one per result transfer with
// byte_valid set; the final character also yields an end-of-message result
// carrying the status (0 ok, 1 bad length, 2 bad character, 3 misplaced
// padding, 4 byte above 0x7F). A decoded zero byte ends the text: it and all
// later bytes are not sent, though they are still checked. On a failed
// message the bytes already sent must be discarded by the host. Rate: one
// character per cycle sustained while out_ready stays high. A character is
// decoded while it sits in the input register and, once the decode stage
// fires, is written into a 4-entry result queue whose head drives the output
// port. The decode stage fires only while at least two queue entries are
// free, so the queue depth and the output side's ready set the throughput
// under backpressure; the final character can place two results in one cycle.
module base64_text_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  // character channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       last_char,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic            end_of_message,
  output logic [2:0]      status
);

  // ---------------------------------------------------------------- input reg
  logic       in_full;
  logic [7:0] char_q;
  logic       last_q;
  logic       fire;       // decode stage consumes the input register

  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_q <= in_char;
      last_q <= last_char;
    end
  end

  // ---------------------------------------------------------- decoder state
  logic [1:0] group_position, group_position_next;
  logic [1:0] length_mod_four, length_mod_four_next;
  logic [7:0] partial_byte, partial_byte_next;
  logic [2:0] pad_run, pad_run_next;
  logic [2:0] latched_error, latched_error_next;
  logic       text_ended, text_ended_next;

  b64dec_pkg::sextet_t sextet;
  logic [7:0]          byte_val;
  logic                have_byte;
  logic                emit_byte;

  always_comb begin
    group_position_next  = group_position;
    length_mod_four_next = length_mod_four + 2'd1;
    partial_byte_next    = partial_byte;
    pad_run_next         = pad_run;
    latched_error_next   = latched_error;
    text_ended_next      = text_ended;
    sextet               = b64dec_pkg::sextet_of(char_q);
    byte_val             = 8'd0;
    have_byte            = 1'b0;
    emit_byte            = 1'b0;

    if (latched_error == b64dec_pkg::ST_OK) begin
      if (char_q == b64dec_pkg::PAD_CHAR) begin
        // at most three pad characters
        if (pad_run >= 3'd3) begin
          latched_error_next = b64dec_pkg::ST_BAD_PAD;
        end else begin
          pad_run_next = pad_run + 3'd1;
        end
      end else if (pad_run != 3'd0) begin
        // data after padding
        latched_error_next = b64dec_pkg::ST_BAD_PAD;
      end else if (sextet[6]) begin
        latched_error_next = b64dec_pkg::ST_BAD_CHAR;
      end else begin
        case (group_position)
          2'd0: begin
            partial_byte_next = {sextet[5:0], 2'b00};
          end
          2'd1: begin
            byte_val          = partial_byte | {6'b000000, sextet[5:4]};
            partial_byte_next = {sextet[3:0], 4'b0000};
            have_byte         = 1'b1;
          end
          2'd2: begin
            byte_val          = partial_byte | {4'b0000, sextet[5:2]};
            partial_byte_next = {sextet[1:0], 6'b000000};
            have_byte         = 1'b1;
          end
          default: begin
            byte_val          = partial_byte | {2'b00, sextet[5:0]};
            partial_byte_next = 8'd0;
            have_byte         = 1'b1;
          end
        endcase
        group_position_next = group_position + 2'd1;
        if (have_byte) begin
          if (byte_val > b64dec_pkg::BYTE_MAX) begin
            latched_error_next = b64dec_pkg::ST_HIGH_BYTE;
          end else if (byte_val == 8'd0) begin
            text_ended_next = 1'b1;
          end else if (!text_ended) begin
            emit_byte = 1'b1;
          end
        end
      end
    end
  end

  // end result: length check wins over any latched error
  b64dec_pkg::result_t byte_res, end_res, push0, push1;
  logic [1:0]          push_n;

  always_comb begin
    byte_res                = '0;
    byte_res.data_byte      = byte_val;
    byte_res.byte_valid     = 1'b1;
    byte_res.status         = b64dec_pkg::ST_OK;

    end_res                 = '0;
    end_res.end_of_message  = 1'b1;
    end_res.status          = (length_mod_four_next != 2'd0) ? b64dec_pkg::ST_BAD_LEN
                                                             : latched_error_next;

    push0  = emit_byte ? byte_res : end_res;
    push1  = end_res;
    push_n = {1'b0, emit_byte} + {1'b0, last_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position  <= 2'd0;
      length_mod_four <= 2'd0;
      partial_byte    <= 8'd0;
      pad_run         <= 3'd0;
      latched_error   <= b64dec_pkg::ST_OK;
      text_ended      <= 1'b0;
    end else if (fire) begin
      if (last_q) begin
        // message done, back to reset state
        group_position  <= 2'd0;
        length_mod_four <= 2'd0;
        partial_byte    <= 8'd0;
        pad_run         <= 3'd0;
        latched_error   <= b64dec_pkg::ST_OK;
        text_ended      <= 1'b0;
      end else begin
        group_position  <= group_position_next;
        length_mod_four <= length_mod_four_next;
        partial_byte    <= partial_byte_next;
        pad_run         <= pad_run_next;
        latched_error   <= latched_error_next;
        text_ended      <= text_ended_next;
      end
    end
  end

  // ----------------------------------------------------------- result queue
  // four entries; decode fires only with two entries free
  b64dec_pkg::result_t q_mem [4];
  logic [1:0]          wr_ptr;
  logic [1:0]          rd_ptr;
  logic [2:0]          q_count;
  logic                pop;

  assign fire      = in_full && (q_count <= 3'd2);
  assign out_valid = (q_count != 3'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (fire && (push_n != 2'd0)) begin
      q_mem[wr_ptr] <= push0;
    end
    if (fire && (push_n == 2'd2)) begin
      q_mem[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 2'd0;
      rd_ptr  <= 2'd0;
      q_count <= 3'd0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      q_count <= q_count + (fire ? {1'b0, push_n} : 3'd0) - {2'b00, pop};
    end
  end

  assign data_byte      = q_mem[rd_ptr].data_byte;
  assign byte_valid     = q_mem[rd_ptr].byte_valid;
  assign end_of_message = q_mem[rd_ptr].end_of_message;
  assign status         = q_mem[rd_ptr].status;

  // ------------------------------------------------------------- assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 3'd4)
    else $error("result queue over four entries");

  a_pad_bound: assert property (@(posedge clk) disable iff (rst)
    pad_run <= 3'd3)
    else $error("pad run above three");

  a_msg_reset: assert property (@(posedge clk) disable iff (rst)
    fire && last_q |=> (group_position == 2'd0) && (length_mod_four == 2'd0) &&
                       (latched_error == b64dec_pkg::ST_OK) && (pad_run == 3'd0) &&
                       !text_ended)
    else $error("state not cleared after end of message");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    fire && !last_q && (latched_error != b64dec_pkg::ST_OK)
      |=> latched_error == $past(latched_error))
    else $error("latched error changed within message");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != end_of_message))
    else $error("result is neither a byte nor an end result");

endmodule

`default_nettype wire
